>>> rtl/core/tmv_pkg.sv
`default_nettype none

package tmv_pkg;

  // field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned ThrW    = 31;
  localparam int unsigned MaskW   = 3;
  localparam int unsigned CountW  = 8;
  localparam int unsigned InW     = 6 * DataW;
  localparam int unsigned OutBits = 2 * DataW + 2 * MaskW + CountW;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  // reset values and codes
  localparam logic [ThrW-1:0]  THR_RESET = ThrW'(1000);
  localparam logic [MaskW-1:0] ALL_OK    = 3'b111;
  localparam logic [MaskW-1:0] NO_FAULT  = 3'b000;

  // one item of redundant channel samples
  typedef struct packed {
    logic signed [DataW-1:0] chan2_velocity_mms;
    logic signed [DataW-1:0] chan1_velocity_mms;
    logic signed [DataW-1:0] chan0_velocity_mms;
    logic signed [DataW-1:0] chan2_altitude_mm;
    logic signed [DataW-1:0] chan1_altitude_mm;
    logic signed [DataW-1:0] chan0_altitude_mm;
  } sample_t;

  // health status of one item
  typedef struct packed {
    logic [MaskW-1:0]  new_fault_mask;
    logic [CountW-1:0] disagreement_total;
    logic [MaskW-1:0]  health_mask;
  } health_t;

endpackage

`default_nettype wire

>>> rtl/core/tmv_median3.sv
`default_nettype none

module tmv_median3
  import tmv_pkg::*;
(
  input  wire logic signed [DataW-1:0] a,
  input  wire logic signed [DataW-1:0] b,
  input  wire logic signed [DataW-1:0] c,
  output logic signed [DataW-1:0]      median
);

  logic a_gt_b;
  logic a_gt_c;
  logic b_gt_c;

  // pairwise signed compares
  assign a_gt_b = a > b;
  assign a_gt_c = a > c;
  assign b_gt_c = b > c;

  // pick the middle value, ties give the shared value
  always_comb begin
    if (a_gt_b) begin
      if (b_gt_c) begin
        median = b;
      end else begin
        median = a_gt_c ? c : a;
      end
    end else begin
      if (a_gt_c) begin
        median = a;
      end else begin
        median = b_gt_c ? c : b;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tmv_health.sv
`default_nettype none

module tmv_health
  import tmv_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic [ThrW-1:0]         threshold,
  input  wire logic signed [DataW-1:0] voted_alt,
  input  wire logic signed [DataW-1:0] alt0,
  input  wire logic signed [DataW-1:0] alt1,
  input  wire logic signed [DataW-1:0] alt2,
  output health_t                      status
);

  logic signed [DataW-1:0] alt [MaskW];
  logic [MaskW-1:0]        health;
  logic [CountW-1:0]       disagree_counter;
  logic [CountW-1:0]       disagree_counter_next;
  logic [MaskW-1:0]        previous_health;

  assign alt[0] = alt0;
  assign alt[1] = alt1;
  assign alt[2] = alt2;

  // per channel distance to the voted altitude, exact at 33 bits
  always_comb begin
    logic signed [DataW:0] diff;
    logic [DataW:0]        mag;
    for (int i = 0; i < MaskW; i++) begin
      diff = {alt[i][DataW-1], alt[i]} - {voted_alt[DataW-1], voted_alt};
      mag  = diff[DataW] ? (~diff + (DataW+1)'(1)) : diff;
      health[i] = mag <= {2'b00, threshold};
    end
  end

  // wrapping disagreement count
  assign disagree_counter_next = (health != ALL_OK) ? disagree_counter + CountW'(1)
                                                    : disagree_counter;

  // status of the item now moving to the result register
  always_comb begin
    status.health_mask        = health;
    status.disagreement_total = disagree_counter_next;
    if ((health != ALL_OK) && (previous_health == ALL_OK)) begin
      status.new_fault_mask = ~health;
    end else begin
      status.new_fault_mask = NO_FAULT;
    end
  end

  // history advances once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      disagree_counter <= '0;
      previous_health  <= ALL_OK;
    end else if (advance) begin
      disagree_counter <= disagree_counter_next;
      previous_health  <= health;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tmr_median_voter_health_core.sv
// Triple redundant altitude/velocity voter with channel health tracking.
//
// Input stream (s_*): one transfer carries three channel altitudes and three
// channel velocities. Output stream (m_*): one transfer per input item with
// the median altitude and velocity, the channel health mask, the running
// disagreement count and the mask of newly faulted channels.
// Config channel (cfg_*): writes the agreement threshold in mm; always ready.
// Write it only while no item is in flight.
//
// An item lands in the input register, then one pass of median, distance and
// compare logic writes the result register. Throughput is one item per cycle
// while the receiver keeps taking results; the median compare, 33-bit
// subtract and threshold compare chain sets the clock period.
// When the receiver stalls, the result register holds; one more item waits
// in the input register, then s_tready drops until results move again.
// Reset empties both registers, clears the disagreement count, marks all
// channels healthy and loads a threshold of 1000 mm.
`default_nettype none

module tmr_median_voter_health_core
  import tmv_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  // input stream
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  // chan0_altitude_mm, chan1_altitude_mm, chan2_altitude_mm,
  // chan0_velocity_mms, chan1_velocity_mms, chan2_velocity_mms
  input  wire logic [InW-1:0]  s_tdata,
  // result stream
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  // voted_altitude_mm, voted_velocity_mms, health_mask,
  // disagreement_total, new_fault_mask, zero pad
  output logic [OutW-1:0]      m_tdata,
  // threshold write
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [ThrW-1:0] cfg_data
);

  logic                    in_valid;
  sample_t                 in_sample;
  logic                    advance;
  logic [ThrW-1:0]         threshold;
  logic signed [DataW-1:0] voted_alt;
  logic signed [DataW-1:0] voted_vel;
  health_t                 status;
  logic signed [DataW-1:0] out_alt;
  logic signed [DataW-1:0] out_vel;
  health_t                 out_status;

  // item moves on when the result register is free or being taken
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // threshold register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample <= sample_t'(s_tdata);
    end
  end

  // median votes
  tmv_median3 u_alt_vote (
    .a      (in_sample.chan0_altitude_mm),
    .b      (in_sample.chan1_altitude_mm),
    .c      (in_sample.chan2_altitude_mm),
    .median (voted_alt)
  );

  tmv_median3 u_vel_vote (
    .a      (in_sample.chan0_velocity_mms),
    .b      (in_sample.chan1_velocity_mms),
    .c      (in_sample.chan2_velocity_mms),
    .median (voted_vel)
  );

  // channel health and fault history
  tmv_health u_health (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .threshold (threshold),
    .voted_alt (voted_alt),
    .alt0      (in_sample.chan0_altitude_mm),
    .alt1      (in_sample.chan1_altitude_mm),
    .alt2      (in_sample.chan2_altitude_mm),
    .status    (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_alt    <= voted_alt;
      out_vel    <= voted_vel;
      out_status <= status;
    end
  end

  assign m_tdata = OutW'({out_status, out_vel, out_alt});

`ifndef SYNTHESIS
  // a new fault is only reported on an unhealthy item
  a_fault_needs_disagree: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status.new_fault_mask != NO_FAULT)
      |-> (out_status.health_mask != ALL_OK))
    else $error("new fault flagged on an all-healthy result");

  // reported new faults are exactly the unhealthy channels
  a_fault_is_inverse: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_status.new_fault_mask != NO_FAULT)
      |-> (out_status.new_fault_mask == ~out_status.health_mask))
    else $error("new fault mask differs from the unhealthy channels");

  // a disagreeing item bumps the count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance && (status.health_mask != ALL_OK)
      |=> (out_status.disagreement_total ==
           $past(u_health.disagree_counter) + CountW'(1)))
    else $error("disagreement count did not advance by one");

  // both registers full and stalled: no new input is taken
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while the pipeline is full and stalled");
`endif

endmodule

`default_nettype wire

>>> tb/tmr_median_voter_health_core_tb.sv
`timescale 1ns / 100ps

module tmr_median_voter_health_core_tb;
  import tmv_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  // one voted result as it sits in m_tdata, highest field first
  typedef struct packed {
    logic [MaskW-1:0]        new_fault_mask;
    logic [CountW-1:0]       disagreement_total;
    logic [MaskW-1:0]        health_mask;
    logic signed [DataW-1:0] voted_velocity_mms;
    logic signed [DataW-1:0] voted_altitude_mm;
  } vote_t;

  logic            clk;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  sample_t         s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [OutW-1:0] m_tdata;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [ThrW-1:0] cfg_data = '0;

  // voter state as the block should hold it
  logic [ThrW-1:0]   thr_model = THR_RESET;
  logic [CountW-1:0] bad_item_count = '0;
  logic [MaskW-1:0]  last_health = ALL_OK;

  sample_t     pending_samples[$];
  vote_t       expected_votes[$];
  int unsigned samples_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned recv_wait = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  logic        hold_off = 1'b0;

  tmr_median_voter_health_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // median of three signed values, ties resolve to the shared value
  function automatic logic signed [DataW-1:0] mid_of_three(
    input logic signed [DataW-1:0] a, b, c);
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    return c;
  endfunction

  // vote one item and advance the health tracking state
  function automatic vote_t vote_and_track(input sample_t s);
    vote_t                   r;
    logic signed [DataW-1:0] alt [3];
    logic [DataW:0]          delta;
    logic [MaskW-1:0]        ok;
    alt[0] = s.chan0_altitude_mm;
    alt[1] = s.chan1_altitude_mm;
    alt[2] = s.chan2_altitude_mm;
    r.voted_altitude_mm  = mid_of_three(alt[0], alt[1], alt[2]);
    r.voted_velocity_mms = mid_of_three(s.chan0_velocity_mms, s.chan1_velocity_mms,
                                        s.chan2_velocity_mms);
    ok = '0;
    // distance taken at 33 bits so full-range spreads never wrap
    for (int i = 0; i < 3; i++) begin
      delta = {alt[i][DataW-1], alt[i]} - {r.voted_altitude_mm[DataW-1], r.voted_altitude_mm};
      if (delta[DataW]) delta = -delta;
      ok[i] = (delta <= {2'b00, thr_model});
    end
    r.new_fault_mask = NO_FAULT;
    if (ok != ALL_OK) begin
      bad_item_count = bad_item_count + 1'b1;
      if (last_health == ALL_OK) r.new_fault_mask = ~ok;
    end
    last_health = ok;
    r.health_mask = ok;
    r.disagreement_total = bad_item_count;
    return r;
  endfunction

  task automatic push_sample(input logic [DataW-1:0] a0, a1, a2, v0, v1, v2);
    sample_t s;
    s.chan0_altitude_mm  = a0;
    s.chan1_altitude_mm  = a1;
    s.chan2_altitude_mm  = a2;
    s.chan0_velocity_mms = v0;
    s.chan1_velocity_mms = v1;
    s.chan2_velocity_mms = v2;
    pending_samples.push_back(s);
  endtask

  function automatic logic [DataW-1:0] pick_base();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  // one channel value around a base, calm keeps it well inside the threshold
  function automatic logic [DataW-1:0] spread(input logic [DataW-1:0] base, input bit calm);
    logic [DataW-1:0] step;
    step = calm ? $urandom_range(0, thr_model / 2) : $urandom_range(0, thr_model);
    if (calm) return $urandom_range(0, 1) ? base + step : base - step;
    case ($urandom_range(0, 6))
      0: return base;
      1: return base + step;
      2: return base - step;
      3: return base + thr_model;
      4: return base - thr_model - 1;
      5: return base + thr_model + 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_random(input int unsigned count);
    bit               calm;
    logic [DataW-1:0] ab, vb;
    repeat (count) begin
      calm = $urandom_range(0, 1);
      ab = pick_base();
      vb = pick_base();
      push_sample(spread(ab, calm), spread(ab, calm), spread(ab, calm),
                  spread(vb, calm), spread(vb, calm), spread(vb, calm));
    end
  endtask

  // block is idle once every item went in and every result came back
  task automatic wait_idle();
    while (pending_samples.size() != 0 || s_tvalid || expected_votes.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_model = value;
  endtask

  task automatic run_phase(input logic [ThrW-1:0] thr, input int unsigned count);
    wait_idle();
    write_threshold(thr);
    add_random(count);
  endtask

  task automatic check_field(input string name, input logic [DataW-1:0] want, got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // input side: offer queued items, predict each one on its transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_votes.push_back(vote_and_track(s_tdata));
        samples_sent <= samples_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples.pop_front();
          send_gap <= send_idle ? $urandom_range(0, 12) : 0;
          if ($urandom_range(0, 99) == 0) send_idle <= !send_idle;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side: compare each transfer, then draw the next stall
  always @(posedge clk) begin : result_side
    int unsigned wait_left;
    vote_t       got;
    vote_t       want;
    if (rst) begin
      m_tready  <= 1'b0;
      recv_wait <= 0;
    end else begin
      wait_left = recv_wait;
      if (m_tvalid && m_tready) begin
        got = vote_t'(m_tdata[OutBits-1:0]);
        if (expected_votes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual 0x%0h", $time, m_tdata);
          mismatches++;
        end else begin
          want = expected_votes.pop_front();
          check_field("voted_altitude_mm", want.voted_altitude_mm, got.voted_altitude_mm);
          check_field("voted_velocity_mms", want.voted_velocity_mms, got.voted_velocity_mms);
          check_field("health_mask", want.health_mask, got.health_mask);
          check_field("disagreement_total", want.disagreement_total,
                      got.disagreement_total);
          check_field("new_fault_mask", want.new_fault_mask, got.new_fault_mask);
        end
        wait_left = recv_idle ? $urandom_range(0, 12) : 0;
        if ($urandom_range(0, 99) == 0) recv_idle <= !recv_idle;
      end else if (wait_left != 0) begin
        wait_left = wait_left - 1;
      end
      recv_wait <= wait_left;
      m_tready  <= (wait_left == 0) && !hold_off;
    end
  end

  // long receiver stall mid-run so the block backs up into its input
  initial begin
    while (samples_sent < 600) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** tmr_median_voter_health_core: FAILED **");
      $finish;
    end
  end

  initial begin
    // directed items at the reset threshold of 1000 mm
    push_sample(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // full-range spread right after an all-healthy item, then repeated
    push_sample(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
    push_sample(32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
    push_sample(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd2, 32'd3);
    push_sample(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd3, 32'd2, 32'd1);
    push_sample(32'd0, 32'd0, 32'd0, 32'd2, 32'd3, 32'd1);
    // distances exactly at and just past the threshold
    push_sample(32'd1000, 32'd0, 32'd0, 32'd1, 32'd3, 32'd2);
    push_sample(32'd0, 32'd1001, 32'd0, 32'd3, 32'd1, 32'd2);
    push_sample(32'd0, 32'd0, -32'sd1001, 32'd2, 32'd1, 32'd3);
    push_sample(32'd0, 32'd0, 32'd0, 32'd5, 32'd5, -32'sd5);
    push_sample(32'd0, 32'd0, -32'sd1000, -32'sd5, 32'd5, 32'd5);
    push_sample(32'd5, -32'sd2000, 32'd3000, 32'hffff_ffff, 32'd0, 32'd1);
    push_sample(32'd100, 32'd100, 32'd200, 32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
    push_sample(-32'sd5, -32'sd5, -32'sd5, 32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0);
    push_sample(32'd1001, 32'd0, -32'sd1001, 32'd7, 32'd7, 32'd7);
    add_random(300);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // threshold sweep, extremes first
    run_phase('0, 450);
    run_phase({ThrW{1'b1}}, 450);
    run_phase(ThrW'($urandom_range(1, 1 << 20)), 300);
    run_phase(ThrW'($urandom), 300);
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("** tmr_median_voter_health_core: PASSED **");
    end else begin
      $display("** tmr_median_voter_health_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tmv_pkg.sv
rtl/core/tmv_median3.sv
rtl/core/tmv_health.sv
rtl/core/tmr_median_voter_health_core.sv
tb/tmr_median_voter_health_core_tb.sv
